>>> rtl/unique_id_stack_with_threshold_scan_macros.svh
`ifndef UNIQUE_ID_STACK_WITH_THRESHOLD_SCAN_MACROS_SVH
`define UNIQUE_ID_STACK_WITH_THRESHOLD_SCAN_MACROS_SVH

// same-cycle implication, checked outside reset
`define UIDSTK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UIDSTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/uidstk_pkg.sv
`default_nettype none
package uidstk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam logic [15:0] THRESHOLD_RESET = 16'd20;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;
  localparam logic [1:0] CMD_LIST = 2'd3;

  localparam logic [2:0] ST_PUSHED = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_POPPED = 3'd3;
  localparam logic [2:0] ST_NONE   = 3'd4;
  localparam logic [2:0] ST_RECORD = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] rec_id;
    logic [15:0] rec_wait;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_wait;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] wt;
  } rec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROT,
    OP_UP,
    OP_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     new_rec;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/uidstk_cell.sv
`default_nettype none
module uidstk_cell import uidstk_pkg::*; (
  input  wire logic clk,
  input  wire cell_op_t op,
  input  wire logic is_tail,
  input  wire rec_t above,
  input  wire rec_t below,
  input  wire rec_t head,
  output rec_t      rec
);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: rec <= rec;
      // rotate toward the top, the top word wraps to the tail
      OP_ROT:  rec <= is_tail ? head : below;
      OP_UP:   rec <= below;
      OP_DOWN: rec <= above;
      default: rec <= rec;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/uidstk_ctrl.sv
`default_nettype none
module uidstk_ctrl import uidstk_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word,
  input  wire logic [15:0] threshold,
  input  wire rec_t      head,
  output cell_ctl_t      ctl,
  output logic [CW-1:0]  count
);

  state_t state, state_next;

  logic [1:0]    cmd_q;
  logic [15:0]   id_q;
  logic [15:0]   wt_q;
  logic [CW-1:0] idx;
  logic          dup;
  logic          pend_valid;
  rec_t          pend;

  logic      can_emit;
  logic      full;
  logic      qual;
  logic      go_walk;
  logic      step;
  logic      emit;
  logic      done;
  out_word_t emit_word;

  assign can_emit = !out_valid || out_ready;
  assign full     = (count == CW'(DEPTH));
  assign qual     = (cmd_q == CMD_LIST) || (head.wt >= threshold);
  assign go_walk  = (in_word.cmd != CMD_POP) && (count != '0)
                    && !((in_word.cmd == CMD_PUSH) && full);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = go_walk ? S_WALK : S_FIN;
      S_WALK: if (step && (idx == count - CW'(1))) state_next = S_FIN;
      S_FIN:  if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    step        = 1'b0;
    emit        = 1'b0;
    done        = 1'b0;
    emit_word   = '0;
    ctl.op      = OP_HOLD;
    ctl.new_rec = '{id: id_q, wt: wt_q};
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_WALK: begin
        if (cmd_q == CMD_PUSH) begin
          step = 1'b1;
        end else if (qual && pend_valid) begin
          // the current, older record also matches, so the held one is not the last
          emit      = can_emit;
          step      = can_emit;
          emit_word = '{status: ST_RECORD, out_id: pend.id, out_wait: pend.wt,
                        last: 1'b0};
        end else begin
          step = 1'b1;
        end
        if (step) ctl.op = OP_ROT;
      end
      S_FIN: begin
        if (can_emit) begin
          emit           = 1'b1;
          done           = 1'b1;
          emit_word.last = 1'b1;
          unique case (cmd_q)
            CMD_PUSH: begin
              if (full) begin
                emit_word.status = ST_FULL;
              end else if (dup) begin
                emit_word.status = ST_DUP;
              end else begin
                emit_word.status = ST_PUSHED;
                ctl.op           = OP_DOWN;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                emit_word.status = ST_NONE;
              end else begin
                emit_word.status   = ST_POPPED;
                emit_word.out_id   = head.id;
                emit_word.out_wait = head.wt;
                ctl.op             = OP_UP;
              end
            end
            default: begin
              if (pend_valid) begin
                emit_word.status   = ST_RECORD;
                emit_word.out_id   = pend.id;
                emit_word.out_wait = pend.wt;
              end else begin
                emit_word.status = ST_NONE;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      dup        <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        idx        <= '0;
        dup        <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == S_WALK && step) begin
        idx <= idx + CW'(1);
        if (cmd_q == CMD_PUSH) begin
          if (head.id == id_q) dup <= 1'b1;
        end else if (qual) begin
          pend_valid <= 1'b1;
        end
      end
      if (ctl.op == OP_DOWN) count <= count + CW'(1);
      else if (ctl.op == OP_UP) count <= count - CW'(1);
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= in_word.cmd;
      id_q  <= in_word.rec_id;
      wt_q  <= in_word.rec_wait;
    end
    if (state == S_WALK && step && cmd_q != CMD_PUSH && qual) pend <= head;
    if (emit) out_word <= emit_word;
  end

endmodule
`default_nettype wire

>>> rtl/unique_id_stack_with_threshold_scan.sv
// push and scan/list walk the held records by rotating the stack; pop and
//   push-when-full skip it; the walk moves one cell per cycle unless output stalls
// one item at a time: a new word is taken only after the last one is done
// scan/list emit at most one word per cycle while the output side takes them
// reset (rst, synchronous): stack empty, threshold 20, no output word pending
`default_nettype none
module unique_id_stack_with_threshold_scan import uidstk_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  `include "unique_id_stack_with_threshold_scan_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0]   threshold;
  cell_ctl_t     ctl;
  logic [CW-1:0] count;
  rec_t          recs [DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  uidstk_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .threshold (threshold),
    .head      (recs[0]),
    .ctl       (ctl),
    .count     (count)
  );

  // cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t above;
    rec_t below;
    if (i == 0) begin : g_first
      assign above = ctl.new_rec;
    end else begin : g_mid
      assign above = recs[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign below = '0;
    end else begin : g_notlast
      assign below = recs[i+1];
    end
    uidstk_cell u_cell (
      .clk     (clk),
      .op      (ctl.op),
      .is_tail (count == CW'(i + 1)),
      .above   (above),
      .below   (below),
      .head    (recs[0]),
      .rec     (recs[i])
    );
  end

  `UIDSTK_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH),
    "fill count beyond depth")
  `UIDSTK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "new word taken while one is in work")
  `UIDSTK_ASSERT_NOW(a_count_moves_with_word, !$past(rst) && (count != $past(count)),
    out_valid && out_word.last, "fill count changed without a final word")
  `UIDSTK_ASSERT_NOW(a_no_push_when_full, count == CW'(DEPTH), ctl.op != OP_DOWN,
    "push into a full stack")

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import uidstk_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int GAP_MAX     = 18;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  unique_id_stack_with_threshold_scan #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the stack, bottom at entry 0
  logic [15:0] held_id [DEPTH];
  logic [15:0] held_wait [DEPTH];
  int          held_count;
  logic [15:0] wait_threshold;

  out_word_t   pending_words[$];
  int          err_count;
  bit          tx_calm;
  bit          rx_calm;
  bit          rx_long_hold;

  typedef struct {
    in_word_t  w;
    int        reps;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: FAIL");
    $finish;
  end

  function automatic out_word_t make_word(input logic [2:0] st, input logic [15:0] id,
                                          input logic [15:0] wt, input logic lst);
    make_word = '{status: st, out_id: id, out_wait: wt, last: lst};
  endfunction

  function automatic void stack_predict(input in_word_t w, ref out_word_t res[$]);
    bit        dup;
    out_word_t tail;
    res.delete();
    case (w.cmd)
      CMD_PUSH: begin
        // fullness wins over the duplicate test
        if (held_count >= DEPTH) begin
          res.push_back(make_word(ST_FULL, '0, '0, 1'b1));
        end else begin
          dup = 1'b0;
          for (int i = 0; i < held_count; i++)
            if (held_id[i] == w.rec_id) dup = 1'b1;
          if (dup) begin
            res.push_back(make_word(ST_DUP, '0, '0, 1'b1));
          end else begin
            held_id[held_count]   = w.rec_id;
            held_wait[held_count] = w.rec_wait;
            held_count++;
            res.push_back(make_word(ST_PUSHED, '0, '0, 1'b1));
          end
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          res.push_back(make_word(ST_NONE, '0, '0, 1'b1));
        end else begin
          held_count--;
          res.push_back(make_word(ST_POPPED, held_id[held_count], held_wait[held_count],
                                  1'b1));
        end
      end
      default: begin
        for (int i = held_count - 1; i >= 0; i--)
          if (w.cmd == CMD_LIST || held_wait[i] >= wait_threshold)
            res.push_back(make_word(ST_RECORD, held_id[i], held_wait[i], 1'b0));
        if (res.size() == 0) begin
          res.push_back(make_word(ST_NONE, '0, '0, 1'b1));
        end else begin
          tail = res.pop_back();
          tail.last = 1'b1;
          res.push_back(tail);
        end
      end
    endcase
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [15:0] id,
                                  input logic [15:0] wt, input int reps, input bit typed,
                                  input out_word_t want);
    dir_row_t row;
    row.w     = '{cmd: cmd, rec_id: id, rec_wait: wt};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic in_word_t random_item(input int push_pct);
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < push_pct) w.cmd = CMD_PUSH;
    else if (r < push_pct + (100 - push_pct) / 2) w.cmd = CMD_POP;
    else if ((r % 2) == 0) w.cmd = CMD_SCAN;
    else w.cmd = CMD_LIST;
    // small id pool so duplicates and a full stack come up often
    case ($urandom_range(0, 3))
      0: w.rec_id = 16'($urandom);
      1: w.rec_id = 16'hFFE0 | 16'($urandom_range(0, 31));
      default: w.rec_id = 16'($urandom_range(0, 23));
    endcase
    case ($urandom_range(0, 3))
      0: w.rec_wait = wait_threshold;
      1: w.rec_wait = wait_threshold - 16'd1;
      2: w.rec_wait = 16'($urandom);
      default: w.rec_wait = 16'($urandom_range(0, 40));
    endcase
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t res[$];
    int        gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    stack_predict(w, res);
    if (typed) pending_words.push_back(want);
    else foreach (res[i]) pending_words.push_back(res[i]);
    gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wait_threshold = v;
  endtask

  // output side: random stall before every word unless calm, one long hold on request
  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      int gap;
      if (rx_long_hold) begin
        gap = LONG_HOLD;
        rx_long_hold = 1'b0;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: status %0d id %0h wait %0h last %0b",
               out_word.status, out_word.out_id, out_word.out_wait, out_word.last);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          err_count++;
        end
        if (out_word.out_id !== want.out_id) begin
          $error("out_id: expected %0h, got %0h", want.out_id, out_word.out_id);
          err_count++;
        end
        if (out_word.out_wait !== want.out_wait) begin
          $error("out_wait: expected %0h, got %0h", want.out_wait, out_word.out_wait);
          err_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_word.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    in_word_t    w;
    logic [15:0] thresholds [PHASES];
    int          push_pct [PHASES];
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_word        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    held_count     = 0;
    wait_threshold = THRESHOLD_RESET;
    err_count      = 0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    rx_long_hold   = 1'b0;
    thresholds = '{16'd0, 16'hFFFF, THRESHOLD_RESET, 16'd1, 16'($urandom), 16'hFFFE};
    push_pct   = '{55, 70, 45, 60, 40, 65};

    // empty stack, then field extremes, then fill to the top
    add_row(CMD_POP,  16'h5A5A, 16'hA5A5, 1, 1'b1, make_word(ST_NONE, '0, '0, 1'b1));
    add_row(CMD_SCAN, 16'h0000, 16'h0000, 1, 1'b1, make_word(ST_NONE, '0, '0, 1'b1));
    add_row(CMD_LIST, 16'hFFFF, 16'hFFFF, 1, 1'b1, make_word(ST_NONE, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'h0000, 16'h0000, 1, 1'b1, make_word(ST_PUSHED, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'hFFFF, 16'hFFFF, 1, 1'b1, make_word(ST_PUSHED, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'h0000, 16'd5,    1, 1'b1, make_word(ST_DUP, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'h1234, 16'd20,   1, 1'b1, make_word(ST_PUSHED, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'h1235, 16'd19,   1, 1'b1, make_word(ST_PUSHED, '0, '0, 1'b1));
    add_row(CMD_SCAN, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(CMD_LIST, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(CMD_POP,  16'h0000, 16'h0000, 1, 1'b1,
            make_word(ST_POPPED, 16'h1235, 16'd19, 1'b1));
    // ids 0x0100.. with waits 10, 13, .. 46
    add_row(CMD_PUSH, 16'h0100, 16'd10, 13, 1'b0, '0);
    add_row(CMD_PUSH, 16'h0200, 16'd7,   1, 1'b1, make_word(ST_FULL, '0, '0, 1'b1));
    add_row(CMD_PUSH, 16'h1234, 16'd7,   1, 1'b1, make_word(ST_FULL, '0, '0, 1'b1));
    add_row(CMD_SCAN, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(CMD_LIST, 16'h0000, 16'h0000, 1, 1'b0, '0);
    add_row(CMD_POP,  16'h0000, 16'h0000, 1, 1'b1,
            make_word(ST_POPPED, 16'h010C, 16'd46, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        w = dir_rows[r].w;
        w.rec_id   = w.rec_id + 16'(k);
        w.rec_wait = w.rec_wait + 16'(3 * k);
        send_word(w, dir_rows[r].typed, dir_rows[r].want);
      end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(thresholds[p]);
      tx_calm = (p == 1) || (p == 3);
      rx_calm = (p == 3) || (p == 4);
      // output side stops for a long stretch while words keep coming
      if (p == 2) rx_long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2) tx_calm = (i < 24);
        if ($urandom_range(0, 24) == 0) wait_drained();
        send_word(random_item(push_pct[p]), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> unique_id_stack_with_threshold_scan.f
+incdir+rtl
rtl/uidstk_pkg.sv
rtl/uidstk_cell.sv
rtl/uidstk_ctrl.sv
rtl/unique_id_stack_with_threshold_scan.sv
tb/tb.sv
